// File: rtl/tdss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_pkg
// Shared types and constants of the slotted sample sender.
// ----------------------------------------------------------------------------
package tdss_pkg;

	// item codes
	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_SAMPLE = 2'd1,
		ACT_SYNC   = 2'd2,
		ACT_PAUSE  = 2'd3
	} action_t;

	// configuration register indexes
	localparam int CFG_INDEX_W = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_NODE_SLOT  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_TOTAL = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_FLAGS = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_NODE_HASH  = 4'd3;

	localparam logic [3:0]  NODE_SLOT_RST  = 4'd3;
	localparam logic [3:0]  SLOT_TOTAL_RST = 4'd9;
	localparam logic [7:0]  BASE_FLAGS_RST = 8'h01;
	localparam logic [31:0] NODE_HASH_RST  = 32'd1;
	localparam logic [7:0]  RATE_RST       = 8'd8;

	localparam logic [7:0]  FLAG_SLOTTED = 8'h08;
	localparam logic [7:0]  FLAG_SYNCED  = 8'h10;
	localparam logic [31:0] NO_CYCLE     = 32'hffff_ffff;

	// shared divider geometry
	localparam int QUOT_W     = 32;
	localparam int DIVISOR_W  = 10;
	localparam int STEP_W     = 6;
	localparam int SLOT_NUM_W = 14;

	localparam int STEPS_PERIOD = 10;
	localparam int STEPS_CYCLE  = 32;
	localparam int STEPS_SLOT   = SLOT_NUM_W;

	localparam logic [QUOT_W-1:0] MS_PER_SECOND = 32'd1000;
	// dividend is left aligned so that only the needed quotient bits are run
	localparam logic [QUOT_W-1:0] MS_ALIGNED = MS_PER_SECOND << (QUOT_W - STEPS_PERIOD);

	typedef struct packed {
		logic [3:0]  node_slot;
		logic [3:0]  slot_total;
		logic [7:0]  base_flags;
		logic [31:0] node_hash;
	} cfg_t;

	typedef struct packed {
		logic                 start;
		logic [QUOT_W-1:0]    dividend;
		logic [DIVISOR_W-1:0] divisor;
		logic [STEP_W-1:0]    steps;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [QUOT_W-1:0]    quot;
		logic [DIVISOR_W-1:0] rem;
	} div_rsp_t;

endpackage

// File: rtl/tdss_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_req_if
// Input item channel: action code, time stamp, sample and rate.
// ----------------------------------------------------------------------------
interface tdss_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [31:0]        now_ms;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic [7:0]         rate_hz;

	modport source (output valid, action, now_ms, quat_w, quat_x, quat_y, quat_z, rate_hz,
		input ready);
	modport sink (input valid, action, now_ms, quat_w, quat_x, quat_y, quat_z, rate_hz,
		output ready);
endinterface

// File: rtl/tdss_frame_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_frame_if
// Output frame channel.
// ----------------------------------------------------------------------------
interface tdss_frame_if;
	logic               valid;
	logic               ready;
	logic [3:0]         out_slot;
	logic [31:0]        out_node_hash;
	logic [31:0]        out_sequence;
	logic [31:0]        out_capture_ms;
	logic [7:0]         out_flags;
	logic signed [15:0] out_w;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic signed [15:0] out_z;

	modport source (output valid, out_slot, out_node_hash, out_sequence, out_capture_ms,
		out_flags, out_w, out_x, out_y, out_z, input ready);
	modport sink (input valid, out_slot, out_node_hash, out_sequence, out_capture_ms,
		out_flags, out_w, out_x, out_y, out_z, output ready);
endinterface

// File: rtl/tdss_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface tdss_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/tdss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_div
// Shared restoring divider, one quotient bit per cycle, left aligned dividend.
// ----------------------------------------------------------------------------
module tdss_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tdss_pkg::div_req_t  req,
	output tdss_pkg::div_rsp_t  rsp
);

	logic [tdss_pkg::QUOT_W-1:0]    d_q;
	logic [tdss_pkg::DIVISOR_W-1:0] r_q;
	logic [tdss_pkg::DIVISOR_W-1:0] div_q;
	logic [tdss_pkg::STEP_W-1:0]    cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [tdss_pkg::DIVISOR_W:0]   trial;
	logic                           ge;
	logic [tdss_pkg::DIVISOR_W:0]   diff;

	always_comb begin
		trial = {r_q, d_q[tdss_pkg::QUOT_W-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
				d_q    <= req.dividend;
				r_q    <= '0;
				div_q  <= req.divisor;
			end else if (busy_q) begin
				d_q   <= {d_q[tdss_pkg::QUOT_W-2:0], ge};
				r_q   <= ge ? diff[tdss_pkg::DIVISOR_W-1:0] : trial[tdss_pkg::DIVISOR_W-1:0];
				cnt_q <= cnt_q - tdss_pkg::STEP_W'(1);
				if (cnt_q == tdss_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = d_q;
	assign rsp.rem  = r_q;

endmodule

// File: rtl/tdss_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_seq
// Item sequencer: sample slot, sync state, slot window check and frame register.
// ----------------------------------------------------------------------------
module tdss_seq (
	input  logic               clk,
	input  logic               arst_n,
	tdss_req_if.sink           req,
	tdss_frame_if.source       frame,
	input  tdss_pkg::cfg_t     cfg,
	output tdss_pkg::div_req_t div_req,
	input  tdss_pkg::div_rsp_t div_rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PERIOD,
		ST_CYCLE,
		ST_LO,
		ST_HI,
		ST_DECIDE
	} state_t;

	localparam int PAD_W = tdss_pkg::QUOT_W - tdss_pkg::SLOT_NUM_W;

	state_t state_q;

	logic signed [15:0] held_w_q, held_x_q, held_y_q, held_z_q;
	logic [31:0] held_capture_q;
	logic [31:0] held_gen_q;
	logic        held_valid_q;
	logic [31:0] sent_gen_q;
	logic [31:0] reserved_q;
	logic [31:0] epoch_q;
	logic [7:0]  rate_q;
	logic        paused_q;
	logic        synced_q;
	logic [31:0] seq_q;

	logic [31:0] elapsed_q;
	logic [tdss_pkg::DIVISOR_W-1:0]  period_q;
	logic [31:0] cycle_q;
	logic [tdss_pkg::DIVISOR_W-1:0]  phase_q;
	logic [tdss_pkg::SLOT_NUM_W-1:0] lo_q;
	logic [tdss_pkg::SLOT_NUM_W-1:0] hi_q;

	logic               frame_valid_q;
	logic [3:0]         frame_slot_q;
	logic [31:0]        frame_hash_q;
	logic [31:0]        frame_seq_q;
	logic [31:0]        frame_capture_q;
	logic [7:0]         frame_flags_q;
	logic signed [15:0] frame_w_q, frame_x_q, frame_y_q, frame_z_q;

	logic        req_fire;
	logic        tick_go;
	logic [7:0]  rate_c;
	logic [3:0]  total_c;
	logic [3:0]  slot_m1;
	logic [tdss_pkg::SLOT_NUM_W-1:0] lo_num;
	logic [tdss_pkg::SLOT_NUM_W-1:0] hi_num;
	logic        in_window;
	logic        out_free;
	logic        emit;
	logic [31:0] gen_inc;
	logic [31:0] gen_next;

	always_comb begin
		req_fire  = req.valid && req.ready;
		rate_c    = (rate_q == 8'd0) ? 8'd1 : rate_q;
		total_c   = (cfg.slot_total == 4'd0) ? 4'd1 : cfg.slot_total;
		slot_m1   = cfg.node_slot - 4'd1;
		tick_go   = req_fire && (req.action == tdss_pkg::ACT_TICK) && !paused_q
			&& held_valid_q && (cfg.node_slot != 4'd0);
		lo_num    = tdss_pkg::SLOT_NUM_W'(slot_m1) * tdss_pkg::SLOT_NUM_W'(period_q);
		hi_num    = tdss_pkg::SLOT_NUM_W'(cfg.node_slot) * tdss_pkg::SLOT_NUM_W'(period_q);
		in_window = (tdss_pkg::SLOT_NUM_W'(phase_q) >= lo_q)
			&& (tdss_pkg::SLOT_NUM_W'(phase_q) < hi_q);
		out_free  = !frame_valid_q || frame.ready;
		emit      = (state_q == ST_DECIDE) && in_window && (cycle_q != reserved_q)
			&& (held_gen_q != sent_gen_q) && out_free;
		gen_inc   = held_gen_q + 32'd1;
		gen_next  = (gen_inc == 32'd0) ? 32'd1 : gen_inc;
	end

	// divider requests: period, then cycle/phase, then window bounds
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = elapsed_q;
		div_req.divisor  = period_q;
		div_req.steps    = tdss_pkg::STEP_W'(tdss_pkg::STEPS_CYCLE);
		case (state_q)
			ST_IDLE: begin
				div_req.start    = tick_go;
				div_req.dividend = tdss_pkg::MS_ALIGNED;
				div_req.divisor  = tdss_pkg::DIVISOR_W'(rate_c);
				div_req.steps    = tdss_pkg::STEP_W'(tdss_pkg::STEPS_PERIOD);
			end
			ST_PERIOD: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = elapsed_q;
				div_req.divisor  = div_rsp.quot[tdss_pkg::DIVISOR_W-1:0];
				div_req.steps    = tdss_pkg::STEP_W'(tdss_pkg::STEPS_CYCLE);
			end
			ST_CYCLE: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = {lo_num, {PAD_W{1'b0}}};
				div_req.divisor  = tdss_pkg::DIVISOR_W'(total_c);
				div_req.steps    = tdss_pkg::STEP_W'(tdss_pkg::STEPS_SLOT);
			end
			ST_LO: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = {hi_num, {PAD_W{1'b0}}};
				div_req.divisor  = tdss_pkg::DIVISOR_W'(total_c);
				div_req.steps    = tdss_pkg::STEP_W'(tdss_pkg::STEPS_SLOT);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			held_gen_q    <= '0;
			held_valid_q  <= 1'b0;
			sent_gen_q    <= '0;
			reserved_q    <= tdss_pkg::NO_CYCLE;
			epoch_q       <= '0;
			rate_q        <= tdss_pkg::RATE_RST;
			paused_q      <= 1'b0;
			synced_q      <= 1'b0;
			seq_q         <= '0;
			frame_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				frame_valid_q <= 1'b1;
			end else if (frame.valid && frame.ready) begin
				frame_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (req.action)
							tdss_pkg::ACT_TICK: begin
								if (tick_go) begin
									elapsed_q <= req.now_ms - epoch_q;
									state_q   <= ST_PERIOD;
								end
							end
							tdss_pkg::ACT_SAMPLE: begin
								held_w_q       <= req.quat_w;
								held_x_q       <= req.quat_x;
								held_y_q       <= req.quat_y;
								held_z_q       <= req.quat_z;
								held_capture_q <= req.now_ms;
								held_gen_q     <= gen_next;
								held_valid_q   <= 1'b1;
							end
							tdss_pkg::ACT_SYNC: begin
								rate_q     <= req.rate_hz;
								paused_q   <= 1'b0;
								synced_q   <= 1'b1;
								epoch_q    <= req.now_ms;
								reserved_q <= tdss_pkg::NO_CYCLE;
							end
							default: begin
								paused_q <= 1'b1;
							end
						endcase
					end
				end
				ST_PERIOD: begin
					if (div_rsp.done) begin
						period_q <= div_rsp.quot[tdss_pkg::DIVISOR_W-1:0];
						state_q  <= ST_CYCLE;
					end
				end
				ST_CYCLE: begin
					if (div_rsp.done) begin
						cycle_q <= div_rsp.quot;
						phase_q <= div_rsp.rem;
						state_q <= ST_LO;
					end
				end
				ST_LO: begin
					if (div_rsp.done) begin
						lo_q    <= div_rsp.quot[tdss_pkg::SLOT_NUM_W-1:0];
						state_q <= ST_HI;
					end
				end
				ST_HI: begin
					if (div_rsp.done) begin
						hi_q    <= div_rsp.quot[tdss_pkg::SLOT_NUM_W-1:0];
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!in_window || (cycle_q == reserved_q)) begin
						state_q <= ST_IDLE;
					end else if (held_gen_q == sent_gen_q) begin
						// stale sample: the cycle is still taken
						reserved_q <= cycle_q;
						state_q    <= ST_IDLE;
					end else if (out_free) begin
						reserved_q      <= cycle_q;
						sent_gen_q      <= held_gen_q;
						seq_q           <= seq_q + 32'd1;
						frame_slot_q    <= cfg.node_slot;
						frame_hash_q    <= cfg.node_hash;
						frame_seq_q     <= seq_q + 32'd1;
						frame_capture_q <= held_capture_q;
						frame_flags_q   <= cfg.base_flags | tdss_pkg::FLAG_SLOTTED
							| (synced_q ? tdss_pkg::FLAG_SYNCED : 8'h00);
						frame_w_q       <= held_w_q;
						frame_x_q       <= held_x_q;
						frame_y_q       <= held_y_q;
						frame_z_q       <= held_z_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready            = (state_q == ST_IDLE);
	assign frame.valid          = frame_valid_q;
	assign frame.out_slot       = frame_slot_q;
	assign frame.out_node_hash  = frame_hash_q;
	assign frame.out_sequence   = frame_seq_q;
	assign frame.out_capture_ms = frame_capture_q;
	assign frame.out_flags      = frame_flags_q;
	assign frame.out_w          = frame_w_q;
	assign frame.out_x          = frame_x_q;
	assign frame.out_y          = frame_y_q;
	assign frame.out_z          = frame_z_q;

endmodule

// File: rtl/tdma_slotted_sample_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdma_slotted_sample_sender
// Time-slotted sender of the latest quaternion sample for one link node.
// ----------------------------------------------------------------------------
// Sample, sync and pause items, and ticks that cannot send (paused, no sample
// held, node slot zero), are taken and finished in the idle state. A tick
// that is checked against the node's window runs four divisions one after
// another on a single serial divider that produces one quotient bit per
// cycle: period (10 bits), cycle and phase (32 bits) and the two window
// bounds (14 bits each), and then goes to a decide state. The frame sits in
// an output register, so new items are taken while a frame waits; a tick
// that has a frame to send waits only while the previous frame is still not
// taken. Configuration writes are taken in every cycle.
module tdma_slotted_sample_sender (
	input  logic         clk,
	input  logic         arst_n,
	tdss_req_if.sink     req,
	tdss_frame_if.source frame,
	tdss_cfg_if.sink     cfg
);

	tdss_pkg::cfg_t     cfg_q;
	tdss_pkg::div_req_t div_req;
	tdss_pkg::div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_slot  <= tdss_pkg::NODE_SLOT_RST;
			cfg_q.slot_total <= tdss_pkg::SLOT_TOTAL_RST;
			cfg_q.base_flags <= tdss_pkg::BASE_FLAGS_RST;
			cfg_q.node_hash  <= tdss_pkg::NODE_HASH_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				tdss_pkg::REG_NODE_SLOT:  cfg_q.node_slot  <= cfg.data[3:0];
				tdss_pkg::REG_SLOT_TOTAL: cfg_q.slot_total <= cfg.data[3:0];
				tdss_pkg::REG_BASE_FLAGS: cfg_q.base_flags <= cfg.data[7:0];
				tdss_pkg::REG_NODE_HASH:  cfg_q.node_hash  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	tdss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tdss_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.frame   (frame),
		.cfg     (cfg_q),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

endmodule

// File: verif/tb_tdma_slotted_sample_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tdma_slotted_sample_sender
// Self-checking bench for the slotted sample sender. A short table of items
// covers the reset behavior, extreme samples, window edges, repeat ticks,
// stale samples, pause, sync with zero and high rates and time wrap. Random
// phases follow, each under its own register setting, with ticks aimed
// mostly into the node window. Every frame is compared field by field
// against its table entry or a local model of the sender.
// ----------------------------------------------------------------------------
module tb_tdma_slotted_sample_sender;

	localparam int HALF_PERIOD     = 6;
	localparam int RESET_CYCLES    = 12;
	localparam int SETTLE_CYCLES   = 100;
	localparam int QUIET_LIMIT     = 4000;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int MAX_IDLE        = 14;

	typedef struct packed {
		tdss_pkg::action_t  action;
		logic [31:0]        now;
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [7:0]         rate;
	} req_item_t;

	typedef struct packed {
		logic [3:0]         slot;
		logic [31:0]        hash;
		logic [31:0]        seq;
		logic [31:0]        capture;
		logic [7:0]         flags;
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} frame_t;

	typedef struct packed {
		req_item_t item;
		logic      typed;
		frame_t    frame;
	} plan_row_t;

	localparam frame_t NO_FRAME = '0;
	localparam int PLAN_ROWS = 24;

	// reset setting: slot 3 of 9, rate 8, so period 125 and window [27, 41)
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// tick with no sample held
		'{'{tdss_pkg::ACT_TICK, 32'd30, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b0,
			NO_FRAME},
		'{'{tdss_pkg::ACT_SAMPLE, 32'd0, 16'sh8000, 16'sh7fff, 16'sh0, 16'shffff, 8'd0},
			1'b0, NO_FRAME},
		// before the window
		'{'{tdss_pkg::ACT_TICK, 32'd10, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b0,
			NO_FRAME},
		'{'{tdss_pkg::ACT_TICK, 32'd30, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b1,
			'{4'd3, 32'd1, 32'd1, 32'd0, 8'h09, 16'sh8000, 16'sh7fff, 16'sh0, 16'shffff}},
		'{'{tdss_pkg::ACT_SAMPLE, 32'd35, 16'sh7fff, 16'sh8000, 16'shffff, 16'sh0, 8'hff},
			1'b0, NO_FRAME},
		// same cycle already reserved
		'{'{tdss_pkg::ACT_TICK, 32'd40, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b0,
			NO_FRAME},
		// first phase of the window in period 1
		'{'{tdss_pkg::ACT_TICK, 32'd152, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b1,
			'{4'd3, 32'd1, 32'd2, 32'd35, 8'h09, 16'sh7fff, 16'sh8000, 16'shffff, 16'sh0}},
		// stale sample, reserves cycle 2 only
		'{'{tdss_pkg::ACT_TICK, 32'd290, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b0,
			NO_FRAME},
		// phase 41 is just past the window
		'{'{tdss_pkg::ACT_TICK, 32'd416, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b0,
			NO_FRAME},
		'{'{tdss_pkg::ACT_PAUSE, 32'd500, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b0,
			NO_FRAME},
		'{'{tdss_pkg::ACT_SAMPLE, 32'd501, 16'sh1, 16'sh2, 16'sh3, 16'sh4, 8'd0}, 1'b0,
			NO_FRAME},
		'{'{tdss_pkg::ACT_TICK, 32'd530, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b0,
			NO_FRAME},
		// zero rate means period 1000, window [222, 333); epoch near the wrap
		'{'{tdss_pkg::ACT_SYNC, 32'hffff_ff00, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b0,
			NO_FRAME},
		'{'{tdss_pkg::ACT_TICK, 32'h0000_002c, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b1,
			'{4'd3, 32'd1, 32'd3, 32'd501, 8'h19, 16'sh1, 16'sh2, 16'sh3, 16'sh4}},
		'{'{tdss_pkg::ACT_SAMPLE, 32'd1000, 16'sh1234, 16'shedcb, 16'sh5a5a, 16'sha5a5,
			8'd0}, 1'b0, NO_FRAME},
		// rate 255, period 3, window [0, 1)
		'{'{tdss_pkg::ACT_SYNC, 32'd5000, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd255}, 1'b0,
			NO_FRAME},
		'{'{tdss_pkg::ACT_TICK, 32'd5021, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b0,
			NO_FRAME},
		// rate 200, period 5, window empty
		'{'{tdss_pkg::ACT_SYNC, 32'd7, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd200}, 1'b0,
			NO_FRAME},
		'{'{tdss_pkg::ACT_SAMPLE, 32'd8, 16'sh0fff, 16'sh7000, 16'sh8001, 16'sh0100, 8'd0},
			1'b0, NO_FRAME},
		'{'{tdss_pkg::ACT_TICK, 32'd8, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b0,
			NO_FRAME},
		'{'{tdss_pkg::ACT_SYNC, 32'd0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd8}, 1'b0,
			NO_FRAME},
		'{'{tdss_pkg::ACT_TICK, 32'd30, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b0,
			NO_FRAME},
		'{'{tdss_pkg::ACT_SAMPLE, 32'hffff_ffff, 16'sh4000, 16'shc000, 16'sh2000,
			16'she000, 8'd0}, 1'b0, NO_FRAME},
		'{'{tdss_pkg::ACT_TICK, 32'hffff_ffff, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'd0}, 1'b0,
			NO_FRAME}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tdss_req_if   req ();
	tdss_frame_if frame ();
	tdss_cfg_if   cfg ();

	tdma_slotted_sample_sender dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.frame  (frame),
		.cfg    (cfg)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// sender model state
	tdss_pkg::cfg_t     shadow_cfg;
	logic signed [15:0] held_w, held_x, held_y, held_z;
	logic [31:0]        held_capture, held_gen, sent_gen;
	logic [31:0]        reserved_cycle, epoch, seq_count;
	logic               held_ok, paused, synced;
	logic [7:0]         rate;

	frame_t      pending_frames [$];
	logic [31:0] aim_cycle;
	bit          tx_steady, rx_steady;
	int unsigned quiet_cycles = 0;
	int unsigned stall_left = 0;
	bit          failed = 1'b0;

	function automatic void slot_window(output logic [31:0] period, output logic [31:0] lo,
		output logic [31:0] hi);
		logic [31:0] total, slot;
		period = tdss_pkg::MS_PER_SECOND / ((rate == 8'd0) ? 32'd1 : {24'd0, rate});
		total = (shadow_cfg.slot_total == 4'd0) ? 32'd1 : {28'd0, shadow_cfg.slot_total};
		slot = {28'd0, shadow_cfg.node_slot};
		// slot zero leaves an empty window
		lo = (slot == 32'd0) ? 32'd0 : ((slot - 32'd1) * period) / total;
		hi = (slot * period) / total;
	endfunction

	function automatic logic predict_frame(input req_item_t it, output frame_t f);
		logic [31:0] period, lo, hi, elapsed, cyc, phase;
		f = NO_FRAME;
		case (it.action)
		tdss_pkg::ACT_SAMPLE: begin
			{held_w, held_x, held_y, held_z} = {it.w, it.x, it.y, it.z};
			held_capture = it.now;
			held_gen = held_gen + 32'd1;
			if (held_gen == 32'd0)
				held_gen = 32'd1;
			held_ok = 1'b1;
			return 1'b0;
		end
		tdss_pkg::ACT_SYNC: begin
			rate = it.rate;
			epoch = it.now;
			paused = 1'b0;
			synced = 1'b1;
			reserved_cycle = tdss_pkg::NO_CYCLE;
			return 1'b0;
		end
		tdss_pkg::ACT_PAUSE: begin
			paused = 1'b1;
			return 1'b0;
		end
		default: ;
		endcase
		if (paused || !held_ok)
			return 1'b0;
		slot_window(period, lo, hi);
		elapsed = it.now - epoch;
		cyc = elapsed / period;
		phase = elapsed % period;
		if (phase < lo || phase >= hi || cyc == reserved_cycle)
			return 1'b0;
		reserved_cycle = cyc;
		if (held_gen == sent_gen)
			return 1'b0;
		sent_gen = held_gen;
		seq_count = seq_count + 32'd1;
		f = '{shadow_cfg.node_slot, shadow_cfg.node_hash, seq_count, held_capture,
			shadow_cfg.base_flags | tdss_pkg::FLAG_SLOTTED
			| (synced ? tdss_pkg::FLAG_SYNCED : 8'h00),
			held_w, held_x, held_y, held_z};
		return 1'b1;
	endfunction

	// mostly samples and ticks aimed into the window, some syncs, pauses and noise
	function automatic req_item_t draw_item();
		req_item_t   it;
		logic [31:0] period, lo, hi;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		it.action = tdss_pkg::action_t'($urandom_range(0, 3));
		it.now = $urandom();
		it.w = 16'($urandom());
		it.x = 16'($urandom());
		it.y = 16'($urandom());
		it.z = 16'($urandom());
		it.rate = 8'($urandom());
		slot_window(period, lo, hi);
		if (pick < 30) begin
			it.action = tdss_pkg::ACT_SAMPLE;
		end else if (pick < 82) begin
			it.action = tdss_pkg::ACT_TICK;
			if (pick < 75 && hi > lo) begin
				case ($urandom_range(0, 9))
				0, 1: ;  // hit the same cycle again
				8, 9: aim_cycle = $urandom() / period;
				default: aim_cycle = aim_cycle + $urandom_range(1, 3);
				endcase
				it.now = epoch + aim_cycle * period + $urandom_range(lo, hi - 32'd1);
			end
		end else if (pick < 92) begin
			it.action = tdss_pkg::ACT_SYNC;
			if (pick < 87)
				it.rate = 8'($urandom_range(0, 16));
			aim_cycle = '0;
		end else if (pick < 94) begin
			it.action = tdss_pkg::ACT_PAUSE;
		end
		return it;
	endfunction

	task automatic send_item(input req_item_t it, input logic typed, input frame_t typed_frame);
		frame_t      predicted;
		logic        produced;
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid   <= 1'b1;
		req.action  <= it.action;
		req.now_ms  <= it.now;
		req.quat_w  <= it.w;
		req.quat_x  <= it.x;
		req.quat_y  <= it.y;
		req.quat_z  <= it.z;
		req.rate_hz <= it.rate;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		produced = predict_frame(it, predicted);
		if (typed)
			pending_frames.push_back(typed_frame);
		else if (produced)
			pending_frames.push_back(predicted);
	endtask

	task automatic write_config(input tdss_pkg::cfg_t c);
		logic [3:0]  idx [4];
		logic [31:0] val [4];
		idx = '{tdss_pkg::REG_NODE_SLOT, tdss_pkg::REG_SLOT_TOTAL, tdss_pkg::REG_BASE_FLAGS,
			tdss_pkg::REG_NODE_HASH};
		val = '{{28'd0, c.node_slot}, {28'd0, c.slot_total}, {24'd0, c.base_flags}, c.node_hash};
		for (int i = 0; i < 4; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[i];
			cfg.data  <= val[i];
			@(posedge clk);
			while (!cfg.ready)
				@(posedge clk);
			case (idx[i])
			tdss_pkg::REG_NODE_SLOT:  shadow_cfg.node_slot = val[i][3:0];
			tdss_pkg::REG_SLOT_TOTAL: shadow_cfg.slot_total = val[i][3:0];
			tdss_pkg::REG_BASE_FLAGS: shadow_cfg.base_flags = val[i][7:0];
			tdss_pkg::REG_NODE_HASH:  shadow_cfg.node_hash = val[i];
			default: ;
			endcase
		end
		cfg.valid <= 1'b0;
	endtask

	// ticks that send nothing may still be running once the last frame is in
	task automatic drain_and_settle();
		req.valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			failed = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		frame_t want;
		if (frame.valid && frame.ready) begin
			if (pending_frames.size() == 0) begin
				$display("%0t: frame expected none actual seq %h", $time, frame.out_sequence);
				failed = 1'b1;
			end else begin
				want = pending_frames.pop_front();
				check_field("out_slot", 32'(want.slot), 32'(frame.out_slot));
				check_field("out_node_hash", want.hash, frame.out_node_hash);
				check_field("out_sequence", want.seq, frame.out_sequence);
				check_field("out_capture_ms", want.capture, frame.out_capture_ms);
				check_field("out_flags", 32'(want.flags), 32'(frame.out_flags));
				check_field("out_w", 32'(want.w), 32'(frame.out_w));
				check_field("out_x", 32'(want.x), 32'(frame.out_x));
				check_field("out_y", 32'(want.y), 32'(frame.out_y));
				check_field("out_z", 32'(want.z), 32'(frame.out_z));
			end
			stall_left = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
		end
		if (stall_left > 0) begin
			frame.ready <= 1'b0;
			stall_left--;
		end else begin
			frame.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(req.valid && req.ready) && !(frame.valid && frame.ready)
			&& !(cfg.valid && cfg.ready))
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tdma_slotted_sample_sender: mismatch");
			$finish;
		end
	end

	initial begin
		tdss_pkg::cfg_t phase_cfg;
		req.valid   = 1'b0;
		req.action  = tdss_pkg::ACT_TICK;
		req.now_ms  = '0;
		req.quat_w  = '0;
		req.quat_x  = '0;
		req.quat_y  = '0;
		req.quat_z  = '0;
		req.rate_hz = '0;
		cfg.valid   = 1'b0;
		cfg.index   = tdss_pkg::REG_NODE_SLOT;
		cfg.data    = '0;
		shadow_cfg  = '{tdss_pkg::NODE_SLOT_RST, tdss_pkg::SLOT_TOTAL_RST,
			tdss_pkg::BASE_FLAGS_RST, tdss_pkg::NODE_HASH_RST};
		{held_w, held_x, held_y, held_z} = '0;
		held_capture   = '0;
		held_gen       = '0;
		sent_gen       = '0;
		reserved_cycle = tdss_pkg::NO_CYCLE;
		epoch          = '0;
		seq_count      = '0;
		held_ok        = 1'b0;
		paused         = 1'b0;
		synced         = 1'b0;
		rate           = tdss_pkg::RATE_RST;
		aim_cycle      = '0;
		tx_steady      = 1'b0;
		rx_steady      = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < PLAN_ROWS; r++)
			send_item(PLAN[r].item, PLAN[r].typed, PLAN[r].frame);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_and_settle();
			case (p)
			0: phase_cfg = '{4'd0, 4'd0, 8'h00, 32'h0000_0000};
			1: phase_cfg = '{4'd9, 4'd9, 8'hff, 32'hffff_ffff};
			2: phase_cfg = '{4'd1, 4'd0, 8'ha5, $urandom()};
			3: phase_cfg = '{4'd7, 4'd4, 8'h5a, $urandom()};  // slot past the period end
			4: phase_cfg = '{4'd1, 4'd1, 8'h00, $urandom()};
			default: phase_cfg = '{4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
				8'($urandom()), $urandom()};
			endcase
			write_config(phase_cfg);
			tx_steady = (p == 2) || ($urandom_range(0, 3) == 0);
			rx_steady = (p == 2) || ($urandom_range(0, 3) == 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_item(draw_item(), 1'b0, NO_FRAME);
		end
		drain_and_settle();

		if (!failed)
			$display("tdma_slotted_sample_sender: match");
		else
			$display("tdma_slotted_sample_sender: mismatch");
		$finish;
	end

endmodule
